// ----- rtl/brs_pkg.sv -----
`default_nettype none
package brs_pkg;

  localparam int NUM_UNKNOWNS_DEF = 16;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int FRAC             = 16;
  localparam int MAG_W            = 47;  // magnitudes up to 2^46

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [3:0]         unknown_index;
    logic signed [31:0] bracket_low;
    logic signed [31:0] bracket_high;
    logic signed [31:0] value_at_low;
    logic signed [31:0] value_new;
    logic [30:0]        tolerance;
  } req_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] next_abscissa;
    logic               converged;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_BRACKET, S_SWAP, S_CONV, S_LIN_T1, S_LIN_P, S_Q0, S_T1, S_T2,
    S_M1, S_M2, S_M3, S_P, S_N1, S_Q, S_PQSIGN, S_L1, S_L2, S_L3, S_ACC, S_NSDIV,
    S_CLAMP, S_ADV, S_COMMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_ACCEPT, OP_LOAD, OP_BRACKET, OP_SWAP, OP_CONV, OP_LIN_T1, OP_LIN_P, OP_Q0,
    OP_T1, OP_T2, OP_M1, OP_M2, OP_M3, OP_P, OP_N1, OP_Q, OP_PQSIGN, OP_L1, OP_L2,
    OP_L3, OP_ACC, OP_NSDIV, OP_CLAMP, OP_ADV, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic conv;
    logic interp;
    logic linear;
    logic accept;
    logic unit_done;
  } status_t;

  function automatic logic unit_op(input op_t op);
    case (op)
      OP_LIN_T1, OP_LIN_P, OP_Q0, OP_T1, OP_T2, OP_M1, OP_M2, OP_M3, OP_P, OP_N1,
      OP_Q, OP_L1, OP_L2, OP_L3, OP_NSDIV: unit_op = 1'b1;
      default: unit_op = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/brs_ram.sv -----
`default_nettype none
module brs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/brs_muldiv.sv -----
`default_nettype none
module brs_muldiv #(
  parameter int XW = 49
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic                 is_div,
  input  wire logic                 big_sat,
  input  wire logic signed [XW-1:0] x,
  input  wire logic signed [XW-1:0] y,
  output logic                      done,
  output logic signed [XW-1:0]      res
);
  import brs_pkg::*;

  localparam int MW  = MAG_W;
  localparam int DIG = 16;
  localparam int ND  = (MW + DIG - 1) / DIG;
  localparam int SW  = ND * DIG;
  localparam int PPW = SW + MW;
  localparam int SH  = MW - FRAC;
  localparam int CW  = $clog2(MW + 1);
  localparam logic signed [XW-1:0] LIM  = {{(XW-MW){1'b0}}, 1'b1, {(MW-1){1'b0}}};
  localparam logic signed [XW-1:0] RSAT = {{(XW-31){1'b0}}, {31{1'b1}}};

  logic signed [XW-1:0] xc, yc;
  logic [MW-1:0]        ax, ay;
  logic                 ovf;

  logic                 busy, mode_div, sat_big, neg;
  logic [CW-1:0]        cnt;
  logic [SW-1:0]        num;
  logic [MW-1:0]        ay_r, quo;
  logic [MW:0]          rem;
  logic [PPW-1:0]       acc;

  logic [DIG-1:0]       digit;
  logic [DIG+MW-1:0]    pp;
  logic [MW:0]          rem2;
  logic [PPW-FRAC-1:0]  prod;
  logic signed [XW-1:0] sat_v, mag;

  always_comb begin
    xc = (x > LIM) ? LIM : ((x < -LIM) ? -LIM : x);
    yc = (y > LIM) ? LIM : ((y < -LIM) ? -LIM : y);
    ax = MW'((xc < 0) ? -xc : xc);
    ay = MW'((yc < 0) ? -yc : yc);
    ovf = (ax >> SH) >= ay;
  end

  assign digit = num[SW-1 -: DIG];
  assign pp    = (DIG+MW)'(digit) * (DIG+MW)'(ay_r);
  assign rem2  = {rem[MW-1:0], num[MW-1]};
  assign prod  = acc[PPW-1:FRAC];

  always_comb begin
    sat_v = sat_big ? LIM : RSAT;
    if (mode_div) begin
      mag = (XW'(quo) > sat_v) ? sat_v : XW'(quo);
    end else begin
      mag = ((PPW-FRAC)'(LIM) < prod) ? LIM : XW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy     <= 1'b1;
        mode_div <= is_div;
        sat_big  <= big_sat;
        neg      <= (x < 0) != (y < 0);
        ay_r     <= ay;
        acc      <= '0;
        rem      <= (MW+1)'(ax >> SH);
        if (is_div) begin
          num <= SW'({ax[SH-1:0], {FRAC{1'b0}}});
          if (ay == '0) begin
            cnt <= '0;
            quo <= (ax == '0) ? '0 : '1;
          end else if (ovf) begin
            cnt <= '0;
            quo <= '1;
          end else begin
            cnt <= CW'(MW);
            quo <= '0;
          end
        end else begin
          num <= SW'(ax);
          cnt <= CW'(ND);
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= neg ? -mag : mag;
        end else begin
          cnt <= cnt - 1'b1;
          if (mode_div) begin
            num <= num << 1;
            if (rem2 >= {1'b0, ay_r}) begin
              rem <= rem2 - {1'b0, ay_r};
              quo <= {quo[MW-2:0], 1'b1};
            end else begin
              rem <= rem2;
              quo <= {quo[MW-2:0], 1'b0};
            end
          end else begin
            num <= num << DIG;
            acc <= (acc << DIG) + PPW'(pp);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/brs_datapath.sv -----
`default_nettype none
module brs_datapath #(
  parameter int NUM_UNKNOWNS = brs_pkg::NUM_UNKNOWNS_DEF,
  parameter int VALUE_WIDTH  = brs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire brs_pkg::cmd_t    cmd,
  output brs_pkg::status_t      st,
  input  wire brs_pkg::req_t    req,
  output brs_pkg::rsp_t         rsp
);
  import brs_pkg::*;

  localparam int PW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int XW = (PW + 2 > 49) ? PW + 2 : 49;
  localparam int AW = (NUM_UNKNOWNS > 1) ? $clog2(NUM_UNKNOWNS) : 1;
  localparam int RW = 3 * PW + 3 * 32 + 31;
  localparam logic signed [XW-1:0] LIM  = {{(XW-47){1'b0}}, 1'b1, 46'b0};
  localparam logic signed [XW-1:0] ONE  = XW'(65536);
  localparam logic signed [XW-1:0] VMAX = {{(XW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN = ~VMAX;

  function automatic logic signed [XW-1:0] absx(input logic signed [XW-1:0] v);
    absx = (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    abs33 = (e < 0) ? -e : e;
  endfunction

  function automatic logic signed [XW-1:0] clampx(input logic signed [XW-1:0] v);
    clampx = (v > LIM) ? LIM : ((v < -LIM) ? -LIM : v);
  endfunction

  req_t                 req_q;
  logic signed [XW-1:0] a_r, b_r, c_r, prev_r, ns_r, p_r, q_r, m_r, n_r, lim1_r, lim2_r;
  logic signed [31:0]   fa_r, fb_r, fc_r, t1_r, t2_r, q0_r, tact_r;
  logic [30:0]          tol_r;
  logic                 conv_r, skip_r;
  logic [NUM_UNKNOWNS-1:0] done_q;

  // state store
  logic [AW-1:0]        waddr, raddr;
  logic [RW-1:0]        rd, wd;
  logic                 we;
  logic [PW-1:0]        rd_a, rd_b, rd_c;
  logic [31:0]          rd_fa, rd_fb, rd_fc;
  logic [30:0]          rd_tol;

  assign raddr = AW'(req.unknown_index);
  assign waddr = AW'(req_q.unknown_index);
  assign {rd_a, rd_b, rd_c, rd_fa, rd_fb, rd_fc, rd_tol} = rd;
  assign wd = {PW'(a_r), PW'(b_r), PW'(c_r), fa_r, fb_r, fc_r, tol_r};
  assign we = (cmd.op == OP_COMMIT) && cmd.start && !skip_r;

  brs_ram #(.WIDTH(RW), .DEPTH(NUM_UNKNOWNS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd),
    .raddr (raddr),
    .rdata (rd)
  );

  // shared multiply / divide
  logic                 u_go, u_div, u_big, u_done;
  logic signed [XW-1:0] ux, uy, u_res;
  logic signed [XW-1:0] cb, ba, t1x, t2x, q0x, tactx;

  assign cb    = c_r - b_r;
  assign ba    = b_r - a_r;
  assign t1x   = XW'(t1_r);
  assign t2x   = XW'(t2_r);
  assign q0x   = XW'(q0_r);
  assign tactx = XW'(tact_r);
  assign u_go  = cmd.start && unit_op(cmd.op);

  always_comb begin
    ux    = '0;
    uy    = '0;
    u_div = 1'b0;
    u_big = 1'b0;
    case (cmd.op)
      OP_LIN_T1: begin ux = XW'(fb_r); uy = XW'(fa_r); u_div = 1'b1; end
      OP_LIN_P:  begin ux = cb;        uy = t1x; end
      OP_Q0:     begin ux = XW'(fa_r); uy = XW'(fc_r); u_div = 1'b1; end
      OP_T1:     begin ux = XW'(fb_r); uy = XW'(fc_r); u_div = 1'b1; end
      OP_T2:     begin ux = XW'(fb_r); uy = XW'(fa_r); u_div = 1'b1; end
      OP_M1:     begin ux = cb;        uy = q0x; end
      OP_M2:     begin ux = m_r;       uy = q0x - t1x; end
      OP_M3:     begin ux = ba;        uy = t1x - ONE; end
      OP_P:      begin ux = t2x;       uy = clampx(m_r - n_r); end
      OP_N1:     begin ux = q0x - ONE; uy = t1x - ONE; end
      OP_Q:      begin ux = n_r;       uy = t2x - ONE; end
      OP_L1:     begin ux = cb;        uy = q_r; end
      OP_L2:     begin ux = tactx;     uy = q_r; end
      OP_L3:     begin ux = prev_r;    uy = q_r; end
      OP_NSDIV:  begin ux = p_r; uy = q_r; u_div = 1'b1; u_big = 1'b1; end
      default:   begin ux = '0;        uy = '0; end
    endcase
  end

  brs_muldiv #(.XW(XW)) u_md (
    .clk     (clk),
    .rst     (rst),
    .go      (u_go),
    .is_div  (u_div),
    .big_sat (u_big),
    .x       (ux),
    .y       (uy),
    .done    (u_done),
    .res     (u_res)
  );

  // status
  logic                 inrange, is_start;
  logic signed [XW-1:0] half_cb, ns_now, m3, m34, sum_b;

  assign inrange  = 32'(req_q.unknown_index) < NUM_UNKNOWNS;
  assign is_start = req_q.action == ACT_START;
  assign half_cb  = (cb + ((cb < 0) ? XW'(1) : XW'(0))) >>> 1;   // truncate toward zero
  assign ns_now   = half_cb;
  assign m3       = m_r + (m_r <<< 1);
  assign m34      = (m3 + ((m3 < 0) ? XW'(3) : XW'(0))) >>> 2;
  assign sum_b    = b_r + ns_r;

  always_comb begin
    st.skip      = !inrange || (!is_start && done_q[waddr]);
    st.conv      = (absx(ns_now) <= tactx) || (fb_r == 0);
    st.interp    = (absx(prev_r) >= tactx) && (abs33(fa_r) > abs33(fb_r));
    st.linear    = a_r == c_r;
    st.accept    = (p_r < lim1_r) && (p_r < lim2_r);
    st.unit_done = u_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= '0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (cmd.start) begin
            req_q <= req;
          end
        end
        OP_LOAD: begin
          skip_r <= st.skip;
          if (!inrange) begin
            b_r    <= '0;
            conv_r <= 1'b0;
          end else if (is_start) begin
            a_r   <= XW'(req_q.bracket_low);
            b_r   <= XW'(req_q.bracket_high);
            c_r   <= XW'(req_q.bracket_low);
            fa_r  <= req_q.value_at_low;
            fb_r  <= req_q.value_new;
            fc_r  <= req_q.value_at_low;
            tol_r <= req_q.tolerance;
          end else if (done_q[waddr]) begin
            b_r    <= XW'($signed(rd_b));
            conv_r <= 1'b1;
          end else begin
            a_r   <= XW'($signed(rd_a));
            b_r   <= XW'($signed(rd_b));
            c_r   <= XW'($signed(rd_c));
            fa_r  <= $signed(rd_fa);
            fb_r  <= req_q.value_new;
            fc_r  <= $signed(rd_fc);
            tol_r <= rd_tol;
          end
        end
        OP_BRACKET: begin
          if ((fb_r > 0 && fc_r > 0) || (fb_r < 0 && fc_r < 0)) begin
            c_r  <= a_r;
            fc_r <= fa_r;
          end
          prev_r <= ba;
          tact_r <= 32'(tol_r >> 1) + 32'sd1;
        end
        OP_SWAP: begin
          if (abs33(fc_r) < abs33(fb_r)) begin
            a_r  <= b_r;
            b_r  <= c_r;
            c_r  <= b_r;
            fa_r <= fb_r;
            fb_r <= fc_r;
            fc_r <= fb_r;
          end
        end
        OP_CONV: begin
          ns_r   <= ns_now;
          conv_r <= st.conv;
        end
        OP_PQSIGN: begin
          if (p_r > 0) begin
            q_r <= -q_r;
          end else begin
            p_r <= -p_r;
          end
        end
        OP_CLAMP: begin
          if (absx(ns_r) < tactx) begin
            ns_r <= (ns_r > 0) ? tactx : -tactx;
          end
        end
        OP_ADV: begin
          a_r  <= b_r;
          fa_r <= fb_r;
          b_r  <= (sum_b > VMAX) ? VMAX : ((sum_b < VMIN) ? VMIN : sum_b);
        end
        OP_COMMIT: begin
          if (cmd.start) begin
            rsp.out_index     <= req_q.unknown_index;
            rsp.next_abscissa <= b_r[31:0];
            rsp.converged     <= conv_r;
            if (!skip_r) begin
              done_q[waddr] <= conv_r;
            end
          end
        end
        default: begin
          if (u_done) begin
            case (cmd.op)
              OP_LIN_T1: t1_r <= u_res[31:0];
              OP_LIN_P: begin
                p_r <= u_res;
                q_r <= ONE - t1x;
              end
              OP_Q0:    q0_r   <= u_res[31:0];
              OP_T1:    t1_r   <= u_res[31:0];
              OP_T2:    t2_r   <= u_res[31:0];
              OP_M1:    m_r    <= u_res;
              OP_M2:    m_r    <= u_res;
              OP_M3:    n_r    <= u_res;
              OP_P:     p_r    <= u_res;
              OP_N1:    n_r    <= u_res;
              OP_Q:     q_r    <= u_res;
              OP_L1:    m_r    <= u_res;
              OP_L2:    lim1_r <= clampx(m34 - (absx(u_res) >>> 1));
              OP_L3:    lim2_r <= absx(u_res) >>> 1;
              OP_NSDIV: ns_r   <= u_res;
              default:  ns_r   <= ns_r;
            endcase
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/brs_ctrl.sv -----
`default_nettype none
module brs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output brs_pkg::cmd_t         cmd,
  input  wire brs_pkg::status_t st
);
  import brs_pkg::*;

  state_t state, state_next;
  logic   issued, issued_next;
  logic   rsp_valid_next;
  logic   commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd.start  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE:    cmd.op = OP_ACCEPT;
      S_LOAD:    cmd.op = OP_LOAD;
      S_BRACKET: cmd.op = OP_BRACKET;
      S_SWAP:    cmd.op = OP_SWAP;
      S_CONV:    cmd.op = OP_CONV;
      S_LIN_T1:  cmd.op = OP_LIN_T1;
      S_LIN_P:   cmd.op = OP_LIN_P;
      S_Q0:      cmd.op = OP_Q0;
      S_T1:      cmd.op = OP_T1;
      S_T2:      cmd.op = OP_T2;
      S_M1:      cmd.op = OP_M1;
      S_M2:      cmd.op = OP_M2;
      S_M3:      cmd.op = OP_M3;
      S_P:       cmd.op = OP_P;
      S_N1:      cmd.op = OP_N1;
      S_Q:       cmd.op = OP_Q;
      S_PQSIGN:  cmd.op = OP_PQSIGN;
      S_L1:      cmd.op = OP_L1;
      S_L2:      cmd.op = OP_L2;
      S_L3:      cmd.op = OP_L3;
      S_ACC:     cmd.op = OP_ACC;
      S_NSDIV:   cmd.op = OP_NSDIV;
      S_CLAMP:   cmd.op = OP_CLAMP;
      S_ADV:     cmd.op = OP_ADV;
      S_COMMIT:  cmd.op = OP_COMMIT;
      default:   cmd.op = OP_ACCEPT;
    endcase

    if (unit_op(cmd.op)) begin
      cmd.start = !issued;
    end

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.start = req_valid;
        if (req_valid) state_next = S_LOAD;
      end
      S_LOAD:    state_next = st.skip ? S_COMMIT : S_BRACKET;
      S_BRACKET: state_next = S_SWAP;
      S_SWAP:    state_next = S_CONV;
      S_CONV: begin
        if (st.conv) begin
          state_next = S_COMMIT;
        end else if (st.interp) begin
          state_next = st.linear ? S_LIN_T1 : S_Q0;
        end else begin
          state_next = S_CLAMP;
        end
      end
      S_LIN_T1: if (st.unit_done) state_next = S_LIN_P;
      S_LIN_P:  if (st.unit_done) state_next = S_PQSIGN;
      S_Q0:     if (st.unit_done) state_next = S_T1;
      S_T1:     if (st.unit_done) state_next = S_T2;
      S_T2:     if (st.unit_done) state_next = S_M1;
      S_M1:     if (st.unit_done) state_next = S_M2;
      S_M2:     if (st.unit_done) state_next = S_M3;
      S_M3:     if (st.unit_done) state_next = S_P;
      S_P:      if (st.unit_done) state_next = S_N1;
      S_N1:     if (st.unit_done) state_next = S_Q;
      S_Q:      if (st.unit_done) state_next = S_PQSIGN;
      S_PQSIGN: state_next = S_L1;
      S_L1:     if (st.unit_done) state_next = S_L2;
      S_L2:     if (st.unit_done) state_next = S_L3;
      S_L3:     if (st.unit_done) state_next = S_ACC;
      S_ACC:    state_next = st.accept ? S_NSDIV : S_CLAMP;
      S_NSDIV:  if (st.unit_done) state_next = S_CLAMP;
      S_CLAMP:  state_next = S_ADV;
      S_ADV:    state_next = S_COMMIT;
      S_COMMIT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.start  = 1'b1;
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (unit_op(cmd.op) && cmd.start) begin
      issued_next = 1'b1;
    end else if (st.unit_done) begin
      issued_next = 1'b0;
    end else begin
      issued_next = issued;
    end

    if (commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_LOAD)
    else $error("accepted request did not enter load");

  a_done_in_unit: assert property (@(posedge clk) disable iff (rst)
    st.unit_done |-> (unit_op(cmd.op) && issued))
    else $error("arithmetic unit finished with no operation pending");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid)
    else $error("committed result not presented");

  a_conv_commit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && st.conv) |=> state == S_COMMIT)
    else $error("converged step did not go to commit");

endmodule
`default_nettype wire

// ----- rtl/brent_root_step.sv -----
// Brent-Dekker root search step engine, one request in flight at a time.
// A skipped request (index out of range, or update of a converged unknown) goes from load
//   to commit; a converging step adds bracket, swap and the convergence check. The next
//   request is taken in the cycle after the result is committed.
// Reset (rst, synchronous, active high) clears the controller, the output valid
//   and the per-unknown converged flags; the bracket store is not cleared.
`default_nettype none
module brent_root_step #(
  parameter int NUM_UNKNOWNS = brs_pkg::NUM_UNKNOWNS_DEF,
  parameter int VALUE_WIDTH  = brs_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire brs_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output brs_pkg::rsp_t      rsp
);
  import brs_pkg::*;

  // controller issues one operation per state; the datapath reports
  // the branch conditions and when the shared arithmetic unit is done
  cmd_t    cmd;
  status_t st;

  brs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .st        (st)
  );

  // datapath holds the bracket store, the step registers and the
  // output register, so a result can wait while the next request is taken
  brs_datapath #(
    .NUM_UNKNOWNS (NUM_UNKNOWNS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire
